// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define DKC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// checked on every edge, reset included
`define DKC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dkc_pkg.sv =====
// ---------------------------------------------------------------------------
// dkc_pkg
// types and constants of the dual kernel 3x3 correlator
// ---------------------------------------------------------------------------
package dkc_pkg;

    localparam int PIX_W    = 8;
    localparam int COEF_W   = 3;
    localparam int KERN_W   = 27;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 12;
    localparam int ROW_W    = 12;
    localparam int OCOL_W   = 10;
    localparam int PART_W   = 13;
    localparam int RESP_W   = 15;
    localparam int CFG_W    = 27;
    localparam int CIDX_W   = 2;
    localparam int ODATA_W  = 56;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd480;
    localparam logic [KERN_W-1:0]   KERN_A_RST = 27'd117900737;
    localparam logic [KERN_W-1:0]   KERN_B_RST = 27'd131858513;

    typedef enum logic [CIDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_KERNEL_A     = 2'd2,
        REG_KERNEL_B     = 2'd3
    } t_cfg_reg;

    // one column of the window, index 0 is the top row
    typedef logic [2:0][PIX_W-1:0]  t_pix_col;
    // one column of a kernel, index 0 is the top row
    typedef logic [2:0][COEF_W-1:0] t_coef_col;

    typedef struct packed {
        logic              last;
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
    } t_pos_tag;

    typedef struct packed {
        logic signed [RESP_W-1:0] resp_a;
        logic signed [RESP_W-1:0] resp_b;
        logic [ROW_W-1:0]         row;
        logic [OCOL_W-1:0]        col;
        logic                     last;
    } t_result;

endpackage

// ===== rtl/dual_kernel_convolution_3x3.sv =====
// a pixel beat passes the stage 1 registers, the stage 2 cells and the output register
// throughput: one pixel beat per clock while skid is empty and clearing is done, set by
//   the line-store read port and the three-cell window that shifts one column per beat
// the output holds one result plus one skid entry; input stalls when skid is full
// reset: synchronous; registers return to 640x480 with sobel x / sobel y, then
//   a clearing pass over every address zeroes both line stores before any beat
// ---------------------------------------------------------------------------
// dual_kernel_convolution_3x3
// streaming 3x3 correlator with two programmable kernels, interior pixels only
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_kernel_convolution_3x3
    import dkc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    // pixel input
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [PIX_W-1:0]   i_s_axis_tdata,  // [7:0] pixel
    input  logic               i_s_axis_tuser,  // [0] frame_start
    // result output
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [ODATA_W-1:0] o_m_axis_tdata,  // response_a, response_b, out_row, out_col
    output logic               o_m_axis_tlast
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int WW  = (WB > WIDTH_W) ? WB : WIDTH_W;
    localparam int XW  = (CW > OCOL_W) ? CW : OCOL_W;

    // configuration registers
    logic [WIDTH_W-1:0]  r_cfg_width;
    logic [HEIGHT_W-1:0] r_cfg_height;
    logic [KERN_W-1:0]   r_kern_a;
    logic [KERN_W-1:0]   r_kern_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RST;
            r_cfg_height <= HEIGHT_RST;
            r_kern_a     <= KERN_A_RST;
            r_kern_b     <= KERN_B_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_wdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_wdata[HEIGHT_W-1:0];
                REG_KERNEL_A:     r_kern_a     <= i_cfg_wdata[KERN_W-1:0];
                REG_KERNEL_B:     r_kern_b     <= i_cfg_wdata[KERN_W-1:0];
                default: ;
            endcase
        end
    end

    // clearing pass over the line stores
    logic          r_clr_busy;
    logic [CW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // pipeline advance: held only while the skid entry is occupied
    logic    r_skid_valid;
    logic    w_adv;
    logic    w_accept;

    assign w_adv           = !r_skid_valid;
    assign o_s_axis_tready = w_adv && !r_clr_busy;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // position of the incoming beat
    logic [CW-1:0]       r_col;
    logic [ROW_W-1:0]    r_row;
    logic [WW-1:0]       w_width;
    logic [HEIGHT_W-1:0] w_height;
    logic [CW-1:0]       w_c;
    logic [ROW_W-1:0]    w_r;
    logic [CW-1:0]       n_col;
    logic [ROW_W-1:0]    n_row;
    logic                w_emit;
    t_pos_tag            w_tag;

    always_comb begin
        logic [CW-1:0]    col_st;
        logic [XW-1:0]    cm1;
        if (WW'(r_cfg_width) < WW'(3)) begin
            w_width = WW'(3);
        end else if (WW'(r_cfg_width) > WW'(MAX_WIDTH)) begin
            w_width = WW'(MAX_WIDTH);
        end else begin
            w_width = WW'(r_cfg_width);
        end
        w_height = (r_cfg_height < HEIGHT_W'(3)) ? HEIGHT_W'(3) : r_cfg_height;

        col_st = i_s_axis_tuser ? '0 : r_col;
        w_r    = i_s_axis_tuser ? '0 : r_row;
        // column wraps when the width shrank under it
        w_c    = (WW'(col_st) >= w_width) ? '0 : col_st;

        w_emit = (w_r >= ROW_W'(2)) && (w_c >= CW'(2)) && (w_r < w_height);
        cm1    = XW'(w_c) - XW'(1);
        w_tag.last = (w_r == w_height - 1'b1) && (WW'(w_c) == w_width - 1'b1);
        w_tag.row  = w_r - 1'b1;
        w_tag.col  = cm1[OCOL_W-1:0];

        if (WW'(w_c) + WW'(1) >= w_width) begin
            n_col = '0;
            n_row = ({1'b0, w_r} + 1'b1 >= {1'b0, w_height}) ? '0 : w_r + 1'b1;
        end else begin
            n_col = w_c + 1'b1;
            n_row = w_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1: line-store read data back, stores written
    logic             r_s1_valid;
    logic             r_s1_emit;
    logic [PIX_W-1:0] r_s1_bot;
    logic [CW-1:0]    r_s1_addr;
    t_pos_tag         r_s1_tag;
    logic             r_byp;
    logic [PIX_W-1:0] r_fwd_top;
    logic [PIX_W-1:0] r_fwd_mid;
    logic [PIX_W-1:0] w_up_q;
    logic [PIX_W-1:0] w_mid_q;
    logic [PIX_W-1:0] w_top;
    logic [PIX_W-1:0] w_mid;
    logic             w_s1_fire;

    assign w_s1_fire = w_adv && r_s1_valid;
    // a beat reading the entry written on the same edge takes the new values
    assign w_top     = r_byp ? r_fwd_top : w_up_q;
    assign w_mid     = r_byp ? r_fwd_mid : w_mid_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_accept;
            r_byp      <= w_accept && r_s1_valid && (r_s1_addr == w_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_emit <= w_emit;
            r_s1_bot  <= i_s_axis_tdata;
            r_s1_addr <= w_c;
            r_s1_tag  <= w_tag;
            r_fwd_top <= w_mid;
            r_fwd_mid <= r_s1_bot;
        end
    end

    logic             w_st_we;
    logic [CW-1:0]    w_st_addr;
    logic [PIX_W-1:0] w_up_wdata;
    logic [PIX_W-1:0] w_mid_wdata;

    assign w_st_we     = r_clr_busy || w_s1_fire;
    assign w_st_addr   = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign w_up_wdata  = r_clr_busy ? '0 : w_mid;
    assign w_mid_wdata = r_clr_busy ? '0 : r_s1_bot;

    dkc_line_store #(.DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_addr),
        .i_wdata (w_up_wdata),
        .i_re    (w_accept),
        .i_raddr (w_c),
        .o_rdata (w_up_q)
    );

    dkc_line_store #(.DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_addr),
        .i_wdata (w_mid_wdata),
        .i_re    (w_accept),
        .i_raddr (w_c),
        .o_rdata (w_mid_q)
    );

    // stage 2: chain of three column cells, cell 0 holds the newest column
    t_pix_col                 w_cell_in  [3];
    t_pix_col                 w_cell_out [3];
    t_coef_col                w_coef_a   [3];
    t_coef_col                w_coef_b   [3];
    logic signed [PART_W-1:0] w_part_a   [3];
    logic signed [PART_W-1:0] w_part_b   [3];

    assign w_cell_in[0] = {r_s1_bot, w_mid, w_top};

    for (genvar gi = 0; gi < 3; gi++) begin : g_cell
        if (gi > 0) begin : g_link
            assign w_cell_in[gi] = w_cell_out[gi-1];
        end
        for (genvar gj = 0; gj < 3; gj++) begin : g_coef
            // cell gi sits at kernel column 2-gi
            assign w_coef_a[gi][gj] = r_kern_a[COEF_W*(3*gj + 2 - gi) +: COEF_W];
            assign w_coef_b[gi][gj] = r_kern_b[COEF_W*(3*gj + 2 - gi) +: COEF_W];
        end
        dkc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_s1_fire),
            .i_col    (w_cell_in[gi]),
            .i_coef_a (w_coef_a[gi]),
            .i_coef_b (w_coef_b[gi]),
            .o_col    (w_cell_out[gi]),
            .o_part_a (w_part_a[gi]),
            .o_part_b (w_part_b[gi])
        );
    end

    logic     r_s2_valid;
    t_pos_tag r_s2_tag;
    t_result  w_res;
    logic     w_s2_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_s2_tag <= r_s1_tag;
        end
    end

    assign w_s2_fire    = w_adv && r_s2_valid;
    assign w_res.resp_a = RESP_W'(w_part_a[0]) + RESP_W'(w_part_a[1]) + RESP_W'(w_part_a[2]);
    assign w_res.resp_b = RESP_W'(w_part_b[0]) + RESP_W'(w_part_b[1]) + RESP_W'(w_part_b[2]);
    assign w_res.row    = r_s2_tag.row;
    assign w_res.col    = r_s2_tag.col;
    assign w_res.last   = r_s2_tag.last;

    // output register plus skid entry
    logic    r_out_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_take;

    assign w_take = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_s2_fire;
            end
        end else if (w_s2_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_s2_fire) begin
                r_out <= w_res;
            end
        end else if (w_s2_fire) begin
            r_skid <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out.col, r_out.row, r_out.resp_b, r_out.resp_a};
    assign o_m_axis_tlast  = r_out.last;

    `DKC_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid full with empty output register")
    `DKC_ASSERT(a_stalled_result_to_skid, i_clk, i_rst_n, (w_s2_fire && r_out_valid && !i_m_axis_tready) |=> r_skid_valid, "result dropped while output stalled")
    `DKC_ASSERT(a_clear_covers_store, i_clk, i_rst_n, $fell(r_clr_busy) |-> ($past(r_clr_addr) == CW'(MAX_WIDTH - 1)), "clearing pass ended early")
    `DKC_ASSERT_ALWAYS(a_no_beat_while_clearing, i_clk, r_clr_busy |-> !(w_s1_fire || r_s2_valid), "pipeline busy during clearing pass")

endmodule

// ===== rtl/dkc_line_store.sv =====
// ---------------------------------------------------------------------------
// dkc_line_store
// one row of pixels, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module dkc_line_store
    import dkc_pkg::*;
#(
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [PIX_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read-first: a read of the address being written returns the old entry
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dkc_cell.sv =====
// ---------------------------------------------------------------------------
// dkc_cell
// one window column: holds three pixels, passes them on, forms both partials
// ---------------------------------------------------------------------------
module dkc_cell
    import dkc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_shift,
    input  t_pix_col                 i_col,
    input  t_coef_col                i_coef_a,
    input  t_coef_col                i_coef_b,
    output t_pix_col                 o_col,
    output logic signed [PART_W-1:0] o_part_a,
    output logic signed [PART_W-1:0] o_part_b
);

    t_pix_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    always_comb begin
        logic signed [PART_W-2:0] pa [3];
        logic signed [PART_W-2:0] pb [3];
        for (int j = 0; j < 3; j++) begin
            pa[j] = $signed(i_coef_a[j]) * $signed({1'b0, r_col[j]});
            pb[j] = $signed(i_coef_b[j]) * $signed({1'b0, r_col[j]});
        end
        o_part_a = PART_W'(pa[0]) + PART_W'(pa[1]) + PART_W'(pa[2]);
        o_part_b = PART_W'(pb[0]) + PART_W'(pb[1]) + PART_W'(pb[2]);
    end

    assign o_col = r_col;

endmodule
